// ===== design/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Included by design files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while the synchronous active-low reset is asserted.
`define DLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define DLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define DLE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/dle_etx_pkg.sv =====
// Shared types and constants for the DLE/ETX deframer.
// No dependencies; used by the channel interfaces and the top level.
package dle_etx_pkg;

    localparam logic [7:0] DLE_CODE          = 8'h10;
    localparam logic [7:0] ETX_CODE          = 8'h03;
    localparam logic [7:0] LENGTH_LIMIT      = 8'd255;
    localparam logic [7:0] MAX_FRAME_LEN_RST = 8'd128;

    // Result queue depth; one item adds at most two results.
    localparam int unsigned RES_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        K_DATA   = 2'd0,
        K_END    = 2'd1,
        K_FULL   = 2'd2,
        K_RESYNC = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] frame_length;
        logic       last;
    } t_result;

endpackage

// ===== design/dle_etx_ifs.sv =====
// Valid/ready channel interfaces for the deframer input bytes and results.
// Depends on dle_etx_pkg for the result kind type.
interface dle_etx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface dle_etx_out_if;
    logic                 valid;
    logic                 ready;
    dle_etx_pkg::t_kind   kind;
    logic [7:0]           data_byte;
    logic [7:0]           frame_length;
    logic                 last;

    modport source (output valid, output kind, output data_byte, output frame_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_length,
                    input last, output ready);
endinterface

// ===== design/dle_etx_frame_deframer.sv =====
// DLE/ETX deframer top level: per-byte state update and a small result queue.
// Depends on dle_etx_pkg, dle_etx_ifs and assert_macros.svh.
//
// Usage:
//   i_in  : one raw link byte per request (valid/ready, payload in_byte).
//   o_out : result requests: kind, data_byte, frame_length, last. Each
//           frame yields its data bytes (type first), then one end, full or
//           resync marker. last flags the final result caused by one byte.
//   i_cfg_wr_en / i_cfg_wr_data : write max_frame_len (reset value 128;
//           0 acts as 1). Write only while the block is idle.
// Results are written into the registered result queue and leave it through o_out.
// Throughput: one byte per cycle while each byte makes at most one result and
//   o_out.ready stays high; a byte that makes two results (data plus full, or
//   resync plus data or full) writes both to the four-entry result queue. The
//   output side, one result per cycle while o_out.ready is high, sets the sustained rate.
// Reset (synchronous, i_rst_n low): expect a start DLE, stored count zero,
//   result queue empty, max_frame_len back to 128.
// Stall: when o_out.ready is low, results hold in the queue; i_in.ready
//   drops once fewer than two free queue slots remain, so nothing is lost.
`include "assert_macros.svh"

module dle_etx_frame_deframer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    dle_etx_in_if.sink           i_in,
    dle_etx_out_if.source        o_out
);

    localparam int unsigned QDEPTH = dle_etx_pkg::RES_QUEUE_DEPTH;
    localparam int unsigned QPW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [5:0] {
        PH_START    = 6'b000001,
        PH_TYPE     = 6'b000010,
        PH_DATA     = 6'b000100,
        PH_DATA_DLE = 6'b001000,
        PH_SYNC     = 6'b010000,
        PH_SYNC_DLE = 6'b100000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_count, n_count;
    logic [7:0] r_max_frame_len;

    dle_etx_pkg::t_result r_q_mem [QDEPTH];
    logic [QPW-1:0]       r_wptr, r_rptr;
    logic [QCW-1:0]       r_q_count, n_q_count;

    logic                 accept, pop;
    logic [7:0]           b;
    logic                 is_dle, is_etx;
    logic [7:0]           lim_lo, lim;
    logic [7:0]           st_base, st_byte, st_inc;
    logic                 st_full;
    logic [1:0]           n_res;
    dle_etx_pkg::t_result res0, res1;

    assign b      = i_in.in_byte;
    assign is_dle = (b == dle_etx_pkg::DLE_CODE);
    assign is_etx = (b == dle_etx_pkg::ETX_CODE);

    // Clamp the register to 1..LENGTH_LIMIT.
    assign lim_lo = (r_max_frame_len == 8'd0) ? 8'd1 : r_max_frame_len;
    assign lim    = (lim_lo > dle_etx_pkg::LENGTH_LIMIT) ? dle_etx_pkg::LENGTH_LIMIT : lim_lo;

    // Shared store path: a type byte, also one that follows a DLE while in sync,
    // starts from an empty frame; an escaped DLE stores the literal DLE code.
    assign st_base = (r_phase == PH_TYPE || r_phase == PH_SYNC_DLE) ? 8'd0 : r_count;
    assign st_byte = (r_phase == PH_DATA_DLE) ? dle_etx_pkg::DLE_CODE : b;
    assign st_inc  = (st_base != 8'hFF) ? st_base + 8'd1 : st_base;
    assign st_full = (st_inc >= lim);

    // Accept while two queue slots are free, the worst case for one byte.
    assign i_in.ready = (r_q_count <= QCW'(QDEPTH - 2));
    assign accept     = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_res   = 2'd0;
        res0    = '{kind: dle_etx_pkg::K_DATA, data_byte: 8'd0, frame_length: 8'd0,
                    last: 1'b0};
        res1    = res0;

        case (r_phase)
            PH_START: begin
                n_phase = is_dle ? PH_TYPE : PH_SYNC;
            end
            PH_DATA_DLE: begin
                if (is_etx) begin
                    // Close the frame with its length.
                    res0.kind         = dle_etx_pkg::K_END;
                    res0.frame_length = r_count;
                    n_res             = 2'd1;
                    n_count           = 8'd0;
                    n_phase           = PH_START;
                end else if (is_dle) begin
                    res0.data_byte = st_byte;
                    n_res          = st_full ? 2'd2 : 2'd1;
                    res1.kind      = dle_etx_pkg::K_FULL;
                    n_count        = st_full ? 8'd0 : st_inc;
                    n_phase        = st_full ? PH_SYNC : PH_DATA;
                end else begin
                    // Drop the partial frame; the byte opens a new one, or fills it at once when the limit is 1.
                    res0.kind = dle_etx_pkg::K_RESYNC;
                    n_res     = 2'd2;
                    if (lim <= 8'd1) begin
                        res1.kind = dle_etx_pkg::K_FULL;
                        n_count   = 8'd0;
                        n_phase   = PH_SYNC;
                    end else begin
                        res1.data_byte = b;
                        n_count        = 8'd1;
                        n_phase        = PH_DATA;
                    end
                end
            end
            PH_TYPE, PH_DATA, PH_SYNC_DLE: begin
                if ((r_phase == PH_TYPE && is_etx) ||
                    (r_phase == PH_SYNC_DLE && (is_dle || is_etx))) begin
                    n_phase = PH_SYNC;
                end else if (r_phase == PH_DATA && is_dle) begin
                    n_phase = PH_DATA_DLE;
                end else begin
                    res0.data_byte = st_byte;
                    n_res          = st_full ? 2'd2 : 2'd1;
                    res1.kind      = dle_etx_pkg::K_FULL;
                    n_count        = st_full ? 8'd0 : st_inc;
                    n_phase        = st_full ? PH_SYNC : PH_DATA;
                end
            end
            PH_SYNC: begin
                if (is_dle) begin
                    n_phase = PH_SYNC_DLE;
                end
            end
            default: begin
                n_phase = PH_START;
                n_count = 8'd0;
            end
        endcase

        if (n_res == 2'd2) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    assign n_q_count = r_q_count + (accept ? QCW'(n_res) : QCW'(0)) - (pop ? QCW'(1) : QCW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_START;
            r_count         <= 8'd0;
            r_max_frame_len <= dle_etx_pkg::MAX_FRAME_LEN_RST;
            r_wptr          <= '0;
            r_rptr          <= '0;
            r_q_count       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_frame_len <= i_cfg_wr_data;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_wptr  <= r_wptr + QPW'(n_res);
            end
            if (pop) begin
                r_rptr <= r_rptr + QPW'(1);
            end
            r_q_count <= n_q_count;
        end
    end

    // Queue payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept && n_res != 2'd0) begin
            r_q_mem[r_wptr] <= res0;
            if (n_res == 2'd2) begin
                r_q_mem[r_wptr + QPW'(1)] <= res1;
            end
        end
    end

    assign o_out.valid        = (r_q_count != '0);
    assign o_out.kind         = r_q_mem[r_rptr].kind;
    assign o_out.data_byte    = r_q_mem[r_rptr].data_byte;
    assign o_out.frame_length = r_q_mem[r_rptr].frame_length;
    assign o_out.last         = r_q_mem[r_rptr].last;

    `DLE_ASSERT(a_queue_no_overflow, i_clk, i_rst_n, r_q_count <= QCW'(QDEPTH), "result queue overflow")
    `DLE_ASSERT(a_end_closes_frame, i_clk, i_rst_n, accept && r_phase == PH_DATA_DLE && is_etx |=> r_phase == PH_START && r_count == 8'd0, "frame end did not return to start")
    `DLE_ASSERT(a_count_idle_zero, i_clk, i_rst_n, (r_phase == PH_START || r_phase == PH_TYPE || r_phase == PH_SYNC || r_phase == PH_SYNC_DLE) |-> r_count == 8'd0, "stored count nonzero outside a frame")
    `DLE_ASSERT(a_silent_byte_keeps_queue, i_clk, i_rst_n, accept && n_res == 2'd0 && !pop |=> $stable(r_q_count), "queue changed on a byte with no result")

endmodule
